/* hw/rtl/drrl_pkg.sv */
// Shared types and constants for the decimal record ring log.
`default_nettype none

package drrl_pkg;

    // Fixed field widths of the command and result words.
    localparam int VALUE_W  = 64;
    localparam int OFS_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int FILL_W   = 10;
    localparam int EVICT_W  = 9;

    // Decimal conversion geometry.
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int LEN_W      = 5;
    localparam int BIT_CNT_W  = 6;

    // Stored characters.
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

    // Command opcodes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EV_TEST,
        ST_EV_SCAN,
        ST_WRITE,
        ST_RD_ADDR,
        ST_RD_OUT
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/decimal_record_ring_log.sv */
// Top level of the decimal record ring log: sequencer, converter and byte store.
//
//   Channel   Direction  Handshake          Contents
//   command   in         start & !busy      i_opcode, i_value, i_read_offset
//   result    out        o_strobe (1 cyc)   o_read_byte, o_byte_valid, o_past_end,
//                                           o_fill_bytes, o_records_evicted
//
// Read: accept, then the registered store read and the result register, then the strobe.
// Push: conversion one bit at a time, leading zeros dropped one digit at a time, one test per evicted record
// plus one, evicted bytes removed one at a time, then the digits and the closing space written.
// Reset clears the sequencer, oldest index and fill count; the store is not cleared.
// busy is high from accept until the strobe; the receiver cannot stall results.
`default_nettype none

module decimal_record_ring_log #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_opcode,
    input  wire logic [drrl_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [drrl_pkg::OFS_W-1:0]    i_read_offset,
    output logic                               o_strobe,
    output logic [drrl_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                               o_byte_valid,
    output logic                               o_past_end,
    output logic [drrl_pkg::FILL_W-1:0]        o_fill_bytes,
    output logic [drrl_pkg::EVICT_W-1:0]       o_records_evicted
);

    // Address, fill count and address-sum widths.
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = ((AW > drrl_pkg::OFS_W) ? AW : drrl_pkg::OFS_W) + 1;

    localparam int BW  = drrl_pkg::BCD_W;
    localparam int DW  = drrl_pkg::DIGIT_W;
    localparam int LW  = drrl_pkg::LEN_W;

    // Control state.
    drrl_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_oldest, n_oldest;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_strobe, n_strobe;

    // Work registers.
    logic [drrl_pkg::VALUE_W-1:0]   r_val, n_val;
    logic [BW-1:0]                  r_bcd, n_bcd;
    logic [drrl_pkg::BIT_CNT_W-1:0] r_bit, n_bit;
    logic [LW-1:0]                  r_len, n_len;
    logic [AW-1:0]                  r_wp, n_wp;
    logic [drrl_pkg::OFS_W-1:0]     r_offset, n_offset;
    logic [drrl_pkg::EVICT_W-1:0]   r_evict, n_evict;

    // Result word registers.
    logic [drrl_pkg::BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_past, n_out_past;
    logic [drrl_pkg::FILL_W-1:0]  r_out_fill, n_out_fill;
    logic [drrl_pkg::EVICT_W-1:0] r_out_evict, n_out_evict;

    // Byte store.
    logic [drrl_pkg::BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic [drrl_pkg::BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [drrl_pkg::BYTE_W-1:0] wr_data;

    // Datapath helpers.
    logic [AW-1:0]        oldest_inc;
    logic [AW-1:0]        wp_inc;
    logic [SW-1:0]        rd_sum;
    logic [AW-1:0]        rd_ring;
    logic                 rd_in_range;
    logic [CW:0]          wr_sum;
    logic [AW-1:0]        wr_start;
    logic                 need_evict;
    logic [BW-1:0]        bcd_adj;
    logic [DW-1:0]        top_digit;

    assign busy              = (r_state != drrl_pkg::ST_IDLE);
    assign o_strobe          = r_strobe;
    assign o_read_byte       = r_out_byte;
    assign o_byte_valid      = r_out_valid;
    assign o_past_end        = r_out_past;
    assign o_fill_bytes      = r_out_fill;
    assign o_records_evicted = r_out_evict;

    // Ring pointer increments with wrap at the buffer size.
    assign oldest_inc = (r_oldest == AW'(BUFFER_BYTES - 1)) ? '0 : r_oldest + 1'b1;
    assign wp_inc     = (r_wp == AW'(BUFFER_BYTES - 1)) ? '0 : r_wp + 1'b1;

    // Read address: oldest plus offset, folded once into the ring.
    assign rd_sum      = SW'(r_oldest) + SW'(r_offset);
    assign rd_ring     = (rd_sum >= SW'(BUFFER_BYTES)) ? AW'(rd_sum - SW'(BUFFER_BYTES))
                                                       : AW'(rd_sum);
    assign rd_in_range = (SW'(r_offset) < SW'(r_fill));

    // First free position: oldest plus fill, folded once into the ring.
    assign wr_sum   = (CW+1)'(r_oldest) + (CW+1)'(r_fill);
    assign wr_start = (wr_sum >= (CW+1)'(BUFFER_BYTES)) ? AW'(wr_sum - (CW+1)'(BUFFER_BYTES))
                                                        : AW'(wr_sum);

    // A record must go while the new digits would reach the buffer size.
    assign need_evict = (r_fill != '0) &&
                        (((CW+1)'(r_fill) + (CW+1)'(r_len)) >= (CW+1)'(BUFFER_BYTES));

    assign top_digit = r_bcd[BW-1 -: DW];

    // Double-dabble correction: every BCD digit of five or more gets three added.
    always_comb begin
        for (int d = 0; d < drrl_pkg::MAX_DIGITS; d++) begin
            if (r_bcd[d*DW +: DW] >= DW'(5)) begin
                bcd_adj[d*DW +: DW] = r_bcd[d*DW +: DW] + DW'(3);
            end else begin
                bcd_adj[d*DW +: DW] = r_bcd[d*DW +: DW];
            end
        end
    end

    // Store read address for the next cycle.
    always_comb begin
        case (r_state)
            drrl_pkg::ST_EV_SCAN: rd_addr = oldest_inc;
            drrl_pkg::ST_RD_ADDR: rd_addr = rd_ring;
            default:              rd_addr = r_oldest;
        endcase
    end

    // Store write: digits most significant first, then the closing space.
    assign wr_en   = (r_state == drrl_pkg::ST_WRITE);
    assign wr_data = (r_len != '0) ? (drrl_pkg::CHAR_ZERO | drrl_pkg::BYTE_W'(top_digit))
                                   : drrl_pkg::CHAR_SPACE;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_fill      = r_fill;
        n_strobe    = 1'b0;
        n_val       = r_val;
        n_bcd       = r_bcd;
        n_bit       = r_bit;
        n_len       = r_len;
        n_wp        = r_wp;
        n_offset    = r_offset;
        n_evict     = r_evict;
        n_out_byte  = r_out_byte;
        n_out_valid = r_out_valid;
        n_out_past  = r_out_past;
        n_out_fill  = r_out_fill;
        n_out_evict = r_out_evict;

        case (r_state)
            drrl_pkg::ST_IDLE: begin
                if (start) begin
                    n_offset = i_read_offset;
                    n_val    = i_value;
                    n_bcd    = '0;
                    n_bit    = '0;
                    n_evict  = '0;
                    n_len    = LW'(drrl_pkg::MAX_DIGITS);
                    if (i_opcode == drrl_pkg::OP_READ) begin
                        n_state = drrl_pkg::ST_RD_ADDR;
                    end else begin
                        n_state = drrl_pkg::ST_CONV;
                    end
                end
            end

            // One binary bit shifts into the BCD register each cycle.
            drrl_pkg::ST_CONV: begin
                n_bcd = {bcd_adj[BW-2:0], r_val[drrl_pkg::VALUE_W-1]};
                n_val = {r_val[drrl_pkg::VALUE_W-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (r_bit == drrl_pkg::BIT_CNT_W'(drrl_pkg::VALUE_W - 1)) begin
                    n_state = drrl_pkg::ST_NORM;
                end
            end

            // Drop leading zero digits one per cycle, keeping at least one.
            drrl_pkg::ST_NORM: begin
                if ((r_len > LW'(1)) && (top_digit == '0)) begin
                    n_bcd = {r_bcd[BW-DW-1:0], DW'(0)};
                    n_len = r_len - 1'b1;
                end else begin
                    n_state = drrl_pkg::ST_EV_TEST;
                end
            end

            // Decide between evicting another record and writing the new one.
            drrl_pkg::ST_EV_TEST: begin
                if (need_evict) begin
                    n_state = drrl_pkg::ST_EV_SCAN;
                end else begin
                    n_wp    = wr_start;
                    n_state = drrl_pkg::ST_WRITE;
                end
            end

            // Remove one byte per cycle; a space or an empty store ends the record.
            drrl_pkg::ST_EV_SCAN: begin
                n_oldest = oldest_inc;
                n_fill   = r_fill - 1'b1;
                if ((r_rd_data == drrl_pkg::CHAR_SPACE) || (r_fill == CW'(1))) begin
                    n_evict = r_evict + 1'b1;
                    n_state = drrl_pkg::ST_EV_TEST;
                end
            end

            // One byte written per cycle; the space closes the record.
            drrl_pkg::ST_WRITE: begin
                n_wp   = wp_inc;
                n_fill = r_fill + 1'b1;
                if (r_len != '0) begin
                    n_bcd = {r_bcd[BW-DW-1:0], DW'(0)};
                    n_len = r_len - 1'b1;
                end else begin
                    n_strobe    = 1'b1;
                    n_out_byte  = '0;
                    n_out_valid = 1'b0;
                    n_out_past  = 1'b0;
                    n_out_fill  = drrl_pkg::FILL_W'(r_fill + 1'b1);
                    n_out_evict = r_evict;
                    n_state     = drrl_pkg::ST_IDLE;
                end
            end

            drrl_pkg::ST_RD_ADDR: begin
                n_state = drrl_pkg::ST_RD_OUT;
            end

            // The store byte is now registered; form the read result.
            drrl_pkg::ST_RD_OUT: begin
                n_strobe    = 1'b1;
                n_out_byte  = rd_in_range ? r_rd_data : '0;
                n_out_valid = rd_in_range;
                n_out_past  = !rd_in_range;
                n_out_fill  = drrl_pkg::FILL_W'(r_fill);
                n_out_evict = '0;
                n_state     = drrl_pkg::ST_IDLE;
            end

            default: begin
                n_state = drrl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= drrl_pkg::ST_IDLE;
            r_oldest <= '0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    // Work and result registers.
    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_bcd       <= n_bcd;
        r_bit       <= n_bit;
        r_len       <= n_len;
        r_wp        <= n_wp;
        r_offset    <= n_offset;
        r_evict     <= n_evict;
        r_out_byte  <= n_out_byte;
        r_out_valid <= n_out_valid;
        r_out_past  <= n_out_past;
        r_out_fill  <= n_out_fill;
        r_out_evict <= n_out_evict;
    end

    // Byte store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

`default_nettype wire
